/* sv/c2m_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2m_pkg: shared types and constants for the CSR to MSR converter
// Field widths, capacity limits, the per-beat result bundle and the
// result record that leaves the block.
// ----------------------------------------------------------------------------
package c2m_pkg;

  localparam int MaxRows    = 1024;
  localparam int MaxNnz     = 65536;

  localparam int ColW       = 10;
  localparam int RowW       = 10;
  localparam int NRowsW     = 11;
  localparam int PosW       = 17;
  localparam int ValW       = 64;

  localparam int QueueDepth = 4;
  localparam int QPtrW      = 2;
  localparam int QCntW      = 3;

  // Input tdata: column, value_bits; padded to whole bytes.
  localparam int InDataW    = 80;
  // Output tdata: position, writes_value, value_word, writes_index, index_word.
  localparam int OutDataW   = 104;
  // Output tuser: matrix_done, dropped.
  localparam int OutUserW   = 2;

  // Everything one input beat causes, kept together until it is serialized.
  typedef struct packed {
    logic            has_ent;    // an off-diagonal entry result exists
    logic            ent_drop;   // that entry was dropped for capacity
    logic [PosW-1:0] ent_pos;
    logic [ValW-1:0] ent_val;
    logic [ColW-1:0] ent_col;
    logic            rend;       // row-end results follow
    logic            first_row;  // index[0] write precedes the diagonal
    logic [RowW-1:0] row_idx;
    logic [ValW-1:0] diag;
    logic [PosW-1:0] base;
    logic [PosW-1:0] ptr;
    logic            last_row;
  } bundle_t;

  typedef struct packed {
    logic [PosW-1:0] position;
    logic            writes_value;
    logic [ValW-1:0] value_word;
    logic            writes_index;
    logic [PosW-1:0] index_word;
    logic            last_of_run;
    logic            matrix_done;
    logic            dropped;
  } result_t;

endpackage

/* sv/c2m_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2m_core: input register and conversion state
// Registers each input beat, classifies the entry against the current row
// and builds the bundle of results that the beat causes.
// ----------------------------------------------------------------------------
module c2m_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [c2m_pkg::NRowsW-1:0] n_rows_i,
  input  logic                     s_valid_i,
  output logic                     s_ready_o,
  input  logic                     has_entry_i,
  input  logic [c2m_pkg::ColW-1:0] column_i,
  input  logic [c2m_pkg::ValW-1:0] value_bits_i,
  input  logic                     row_end_i,
  input  logic                     full_i,
  output logic                     push_o,
  output c2m_pkg::bundle_t         bundle_o
);
  import c2m_pkg::*;

  logic            in_valid_q;
  logic            has_q;
  logic [ColW-1:0] col_q;
  logic [ValW-1:0] val_q;
  logic            rend_q;

  logic [RowW-1:0] row_q, row_d;
  logic [PosW-1:0] cnt_q, cnt_d;
  logic [ValW-1:0] diag_q, diag_d;

  logic [NRowsW-1:0] rows;
  logic [PosW-1:0]   base;
  logic              is_diag, is_off, drop, store, last_row, produces, advance;
  logic [PosW-1:0]   cnt_next;
  logic [ValW-1:0]   diag_cur;

  always_comb begin
    if (n_rows_i == '0) begin
      rows = NRowsW'(1);
    end else if (n_rows_i > NRowsW'(MaxRows)) begin
      rows = NRowsW'(MaxRows);
    end else begin
      rows = n_rows_i;
    end
    base     = PosW'(rows) + PosW'(1);
    is_diag  = has_q && (col_q == row_q);
    is_off   = has_q && !is_diag;
    drop     = is_off && (cnt_q >= PosW'(MaxNnz));
    store    = is_off && !drop;
    cnt_next = store ? cnt_q + PosW'(1) : cnt_q;
    diag_cur = is_diag ? val_q : diag_q;
    last_row = ({1'b0, row_q} + NRowsW'(1)) >= rows;
    produces = is_off || rend_q;
    advance  = in_valid_q && (!produces || !full_i);

    bundle_o.has_ent   = is_off;
    bundle_o.ent_drop  = drop;
    bundle_o.ent_pos   = base + cnt_q;
    bundle_o.ent_val   = val_q;
    bundle_o.ent_col   = col_q;
    bundle_o.rend      = rend_q;
    bundle_o.first_row = (row_q == '0);
    bundle_o.row_idx   = row_q;
    bundle_o.diag      = diag_cur;
    bundle_o.base      = base;
    bundle_o.ptr       = base + cnt_next;
    bundle_o.last_row  = last_row;

    row_d  = row_q;
    cnt_d  = cnt_next;
    diag_d = diag_cur;
    if (rend_q) begin
      diag_d = '0;
      if (last_row) begin
        row_d = '0;
        cnt_d = '0;
      end else begin
        row_d = row_q + RowW'(1);
      end
    end
  end

  assign push_o    = advance && produces;
  assign s_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      row_q      <= '0;
      cnt_q      <= '0;
      diag_q     <= '0;
    end else begin
      if (s_ready_o) begin
        in_valid_q <= s_valid_i;
      end
      if (advance) begin
        row_q  <= row_d;
        cnt_q  <= cnt_d;
        diag_q <= diag_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      has_q  <= has_entry_i;
      col_q  <= column_i;
      val_q  <= value_bits_i;
      rend_q <= row_end_i;
    end
  end

endmodule

/* sv/c2m_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2m_queue: short bundle queue
// Holds result bundles so that the extra results of a row end do not
// stall the input side.
// ----------------------------------------------------------------------------
module c2m_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  c2m_pkg::bundle_t bundle_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output c2m_pkg::bundle_t head_o
);
  import c2m_pkg::*;

  bundle_t          mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_pop;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= bundle_i;
    end
  end

endmodule

/* sv/c2m_ser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2m_ser: result serializer
// Walks the head bundle one result per beat in the fixed order entry,
// index[0], diagonal, row pointer, into the output register.
// ----------------------------------------------------------------------------
module c2m_ser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  c2m_pkg::bundle_t head_i,
  output logic             pop_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output c2m_pkg::result_t res_o
);
  import c2m_pkg::*;

  localparam logic [1:0] StepEnt  = 2'd0;
  localparam logic [1:0] StepIdx0 = 2'd1;
  localparam logic [1:0] StepDiag = 2'd2;
  localparam logic [1:0] StepPtr  = 2'd3;

  logic [3:0] done_q;
  logic [3:0] init_mask, cur, rest;
  logic [1:0] step;
  logic       load, valid_q;
  result_t    res_d, res_q;

  always_comb begin
    init_mask = {head_i.rend, head_i.rend, head_i.rend && head_i.first_row, head_i.has_ent};
    cur       = init_mask & ~done_q;
    if (cur[0]) begin
      step = StepEnt;
    end else if (cur[1]) begin
      step = StepIdx0;
    end else if (cur[2]) begin
      step = StepDiag;
    end else begin
      step = StepPtr;
    end
    rest = cur & ~(4'b0001 << step);

    res_d = '0;
    case (step)
      StepEnt: begin
        res_d.dropped = head_i.ent_drop;
        if (!head_i.ent_drop) begin
          res_d.position     = head_i.ent_pos;
          res_d.writes_value = 1'b1;
          res_d.value_word   = head_i.ent_val;
          res_d.writes_index = 1'b1;
          res_d.index_word   = PosW'(head_i.ent_col);
        end
      end
      StepIdx0: begin
        res_d.writes_index = 1'b1;
        res_d.index_word   = head_i.base;
      end
      StepDiag: begin
        res_d.position     = PosW'(head_i.row_idx);
        res_d.writes_value = 1'b1;
        res_d.value_word   = head_i.diag;
      end
      default: begin
        res_d.position     = PosW'(head_i.row_idx) + PosW'(1);
        res_d.writes_index = 1'b1;
        res_d.index_word   = head_i.ptr;
        res_d.matrix_done  = head_i.last_row;
      end
    endcase
    res_d.last_of_run = (rest == '0);
  end

  assign load      = head_valid_i && (!valid_q || m_ready_i);
  assign pop_o     = load && (rest == '0);
  assign m_valid_o = valid_q;
  assign res_o     = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        done_q  <= (rest == '0) ? 4'b0000 : (done_q | (4'b0001 << step));
      end else if (m_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

endmodule

/* sv/csr_to_msr_sparse_convert_top.sv */
`timescale 1ns / 1ps
// Results pass the input register, bundle queue and output register in that order.
// Throughput: one input beat per cycle while each beat yields at most one result
// and the output is not stalled; a row end yields up to three extra results, one per
// cycle, absorbed by a four-entry bundle queue in front of the output register.
// Reset clears the row counter, entry count and held diagonal; n_rows resets to 1.
// ----------------------------------------------------------------------------
// csr_to_msr_sparse_convert_top: CSR to MSR stream converter
// Turns a row-ordered stream of CSR nonzeros into MSR array writes.
// ----------------------------------------------------------------------------
module csr_to_msr_sparse_convert_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [c2m_pkg::NRowsW-1:0]   cfg_wdata_i,    // n_rows
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [c2m_pkg::InDataW-1:0]  s_axis_tdata,   // column, value_bits
  input  logic                         s_axis_tuser,   // has_entry
  input  logic                         s_axis_tlast,   // row_end
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // position, writes_value, value_word, writes_index, index_word
  output logic [c2m_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [c2m_pkg::OutUserW-1:0] m_axis_tuser,   // matrix_done, dropped
  output logic                         m_axis_tlast    // last_of_run
);
  import c2m_pkg::*;

  logic [NRowsW-1:0] n_rows_q;
  logic              push, full, pop, q_valid;
  bundle_t           bundle, head;
  result_t           res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_rows_q <= NRowsW'(1);
    end else if (cfg_we_i) begin
      n_rows_q <= cfg_wdata_i;
    end
  end

  c2m_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_rows_i    (n_rows_q),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .has_entry_i (s_axis_tuser),
    .column_i    (s_axis_tdata[ColW-1:0]),
    .value_bits_i(s_axis_tdata[ColW+ValW-1:ColW]),
    .row_end_i   (s_axis_tlast),
    .full_i      (full),
    .push_o      (push),
    .bundle_o    (bundle)
  );

  c2m_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .bundle_i(bundle),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  c2m_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(q_valid),
    .head_i      (head),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {4'b0000, res.index_word, res.writes_index, res.value_word,
                         res.writes_value, res.position};
  assign m_axis_tuser = {res.dropped, res.matrix_done};
  assign m_axis_tlast = res.last_of_run;

endmodule

/* sv/c2m_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2m_checker: port-level checks for the CSR to MSR converter
// Watches the output stream for stall behavior and result consistency.
// ----------------------------------------------------------------------------
module c2m_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [c2m_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [c2m_pkg::OutUserW-1:0] m_axis_tuser,
  input logic                         m_axis_tlast
);
  import c2m_pkg::*;

  // A stalled beat holds its contents.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // A dropped entry writes nothing and points at position zero.
  a_drop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |->
      !m_axis_tdata[17] && !m_axis_tdata[82] && (m_axis_tdata[16:0] == '0))
    else $error("dropped beat carries a write");

  // The closing row pointer is the final beat of its run and writes the index array.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata[82] && !m_axis_tdata[17])
    else $error("matrix_done on a beat that is not a final pointer write");

  // Unused words are zero.
  a_zero_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[17] || (m_axis_tdata[81:18] == '0)) &&
      (m_axis_tdata[82] || (m_axis_tdata[99:83] == '0)))
    else $error("unused value or index word is not zero");

endmodule

bind csr_to_msr_sparse_convert_top c2m_checker u_c2m_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
